@@ rtl/bsfe_pkg.sv @@
package bsfe_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	// longest run one request can cause: flag, escaped byte, escaped checksum, flag
	localparam int MAX_RUN = 6;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);

	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;   // bytes[0] goes out first
		logic [RUN_W-1:0]        count;   // 1..MAX_RUN
		logic                    closes;  // run ends with the closing flag
	} burst_t;

endpackage

@@ rtl/bsfe_serializer.sv @@
module bsfe_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load_valid,
	input  bsfe_pkg::burst_t burst,
	output logic            load_ready,
	output logic            byte_valid,
	input  logic            byte_stall,
	output logic [7:0]      out_byte,
	output logic            run_end,
	output logic            frame_end
);

	logic [bsfe_pkg::MAX_RUN-1:0][7:0] buf_q;
	logic [bsfe_pkg::RUN_W-1:0]        rem_q;
	logic                              closes_q;
	logic                              take;
	logic                              load;

	assign byte_valid = (rem_q != '0);
	assign take       = byte_valid && !byte_stall;
	// refill in the cycle the final byte of a run leaves
	assign load_ready = (rem_q == '0) || ((rem_q == bsfe_pkg::RUN_W'(1)) && take);
	assign load       = load_valid && load_ready;

	assign out_byte  = buf_q[0];
	assign run_end   = (rem_q == bsfe_pkg::RUN_W'(1));
	assign frame_end = run_end && closes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= burst.count;
		end else if (take) begin
			rem_q <= rem_q - bsfe_pkg::RUN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q    <= burst.bytes;
			closes_q <= burst.closes;
		end else if (take) begin
			buf_q <= buf_q >> 8;
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= bsfe_pkg::RUN_W'(bsfe_pkg::MAX_RUN))
		else $error("run counter beyond maximum run");

	a_frame_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && frame_end) |-> (out_byte == bsfe_pkg::FLAG_BYTE))
		else $error("frame end not on a flag byte");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> byte_valid)
		else $error("loaded run not presented");

endmodule

@@ rtl/byte_stuff_frame_encoder.sv @@
// Channel   Handshake                 Payload
// input     item_valid / item_stall   data_byte, first_byte, last_byte
// output    byte_valid / byte_stall   out_byte, run_end, frame_end
// config    escape_we                 escape_wdata
//
// Each request yields 1 to 6 output bytes, one per cycle while byte_stall is
// low, so the output serializer sets the rate.
// Serializer idle: an accepted request is registered in s1, then loaded into the serializer buffer.
// s1 takes a new request while the serializer drains a run; item_stall is high
// only while s1 is full and the serializer cannot load it.
// Reset clears the running sum, the valid flags and sets escape_control_chars.
module byte_stuff_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       escape_we,
	input  logic       escape_wdata,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       frame_end
);

	logic       escape_control_chars_q;
	logic [7:0] sum_q;

	// s1: accepted request with escape decision and checksum already resolved
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       last_s1;
	logic       esc_s1;
	logic [7:0] check_s1;

	logic       accept;
	logic       move;
	logic       load_ready;
	logic [7:0] sum_next;
	logic       esc_in;
	bsfe_pkg::burst_t burst;

	assign item_stall = valid_s1 && !load_ready;
	assign accept     = item_valid && !item_stall;
	assign move       = valid_s1 && load_ready;

	// first byte restarts the sum; raw payload bytes are summed mod 256
	assign sum_next = (first_byte ? 8'h00 : sum_q) + data_byte;

	assign esc_in = (data_byte == bsfe_pkg::FLAG_BYTE) ||
	                (data_byte == bsfe_pkg::ESC_BYTE) ||
	                (escape_control_chars_q && (data_byte < bsfe_pkg::CTRL_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_control_chars_q <= 1'b1;
		end else if (escape_we) begin
			escape_control_chars_q <= escape_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= 8'h00;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				sum_q <= last_byte ? 8'h00 : sum_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
			esc_s1   <= esc_in;
			check_s1 <= 8'h00 - sum_next;
		end
	end

	// pack the run: [flag] byte-or-escape-pair [checksum-or-pair flag]
	always_comb begin
		logic [bsfe_pkg::RUN_W-1:0] n;
		logic                       check_esc;
		n         = '0;
		check_esc = (check_s1 == bsfe_pkg::ESC_BYTE) || (check_s1 == bsfe_pkg::FLAG_BYTE);
		burst     = '0;
		if (first_s1) begin
			burst.bytes[n] = bsfe_pkg::FLAG_BYTE;
			n = n + bsfe_pkg::RUN_W'(1);
		end
		if (esc_s1) begin
			burst.bytes[n] = bsfe_pkg::ESC_BYTE;
			n = n + bsfe_pkg::RUN_W'(1);
			burst.bytes[n] = data_s1 ^ bsfe_pkg::ESC_XOR;
		end else begin
			burst.bytes[n] = data_s1;
		end
		n = n + bsfe_pkg::RUN_W'(1);
		if (last_s1) begin
			if (check_esc) begin
				burst.bytes[n] = bsfe_pkg::ESC_BYTE;
				n = n + bsfe_pkg::RUN_W'(1);
				burst.bytes[n] = check_s1 ^ bsfe_pkg::ESC_XOR;
			end else begin
				burst.bytes[n] = check_s1;
			end
			n = n + bsfe_pkg::RUN_W'(1);
			burst.bytes[n] = bsfe_pkg::FLAG_BYTE;
			n = n + bsfe_pkg::RUN_W'(1);
		end
		burst.count  = n;
		burst.closes = last_s1;
	end

	bsfe_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.burst      (burst),
		.load_ready (load_ready),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.frame_end  (frame_end)
	);

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty s1");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (sum_q == 8'h00))
		else $error("running sum not cleared after frame end");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(move && !accept) |=> !valid_s1)
		else $error("s1 kept a request already handed on");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	// one payload request on the input channel
	typedef struct {
		logic [7:0] data;
		logic       is_first;
		logic       is_last;
	} payload_req_t;

	// one byte of the encoded stream as the output channel shows it
	typedef struct {
		logic [7:0] value;
		logic       run_end;
		logic       frame_end;
	} line_byte_t;

	// DUT ports; every input starts at a known value
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       escape_we    = 1'b0;
	logic       escape_wdata = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	logic [7:0] data_byte    = 8'h00;
	logic       first_byte   = 1'b0;
	logic       last_byte    = 1'b0;
	logic       byte_valid;
	logic       byte_stall   = 1'b0;
	logic [7:0] out_byte;
	logic       run_end;
	logic       frame_end;

	// requests waiting for the driver, and the encoded bytes still owed by the DUT
	payload_req_t pending_reqs[$];
	line_byte_t   owed_bytes[$];

	// encoder state as the checker tracks it; reset values of the block
	logic [7:0] frame_sum     = 8'h00;
	logic       ctrl_escaping = 1'b1;

	// bookkeeping
	int  reqs_queued    = 0;
	int  reqs_encoded   = 0;
	int  bytes_checked  = 0;
	int  frames_closed  = 0;
	int  escapes_seen   = 0;
	int  error_count    = 0;
	logic req_taken     = 1'b0;

	// idling controls, set per phase by the stimulus block
	int sender_idle_pct  = 0;
	int recv_stall_pct   = 0;
	payload_req_t next_req;

	byte_stuff_frame_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.escape_we   (escape_we),
		.escape_wdata(escape_wdata),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte    (out_byte),
		.run_end     (run_end),
		.frame_end   (frame_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Expected-byte generation
	// ------------------------------------------------------------------

	function automatic void owe_byte(input logic [7:0] value, input logic closes);
		line_byte_t lb;
		lb.value     = value;
		lb.run_end   = 1'b0;
		lb.frame_end = closes;
		owed_bytes.push_back(lb);
	endfunction

	// byte stuffing: escaped bytes go out as ESC then the byte flipped by ESC_XOR
	function automatic void owe_stuffed(input logic [7:0] value, input logic escaped);
		if (escaped) begin
			owe_byte(bsfe_pkg::ESC_BYTE, 1'b0);
			owe_byte(value ^ bsfe_pkg::ESC_XOR, 1'b0);
		end else begin
			owe_byte(value, 1'b0);
		end
	endfunction

	// Works out the full byte run one accepted request causes, in order.
	function automatic void encode_request(input logic [7:0] b, input logic is_first,
			input logic is_last);
		logic [7:0] checksum;
		logic       escaped;
		// a first byte always restarts the sum, even inside an open frame
		if (is_first) begin
			frame_sum = 8'h00;
			owe_byte(bsfe_pkg::FLAG_BYTE, 1'b0);
		end
		// control chars only count when the mode bit is on; compare unsigned
		escaped = (b == bsfe_pkg::FLAG_BYTE) || (b == bsfe_pkg::ESC_BYTE) ||
			(ctrl_escaping && b < bsfe_pkg::CTRL_LIMIT);
		if (escaped)
			escapes_seen++;
		owe_stuffed(b, escaped);
		frame_sum = frame_sum + b;
		if (is_last) begin
			// checksum is the two's complement of the sum; only flag/escape get stuffed
			checksum = 8'h00 - frame_sum;
			owe_stuffed(checksum,
				checksum == bsfe_pkg::ESC_BYTE || checksum == bsfe_pkg::FLAG_BYTE);
			owe_byte(bsfe_pkg::FLAG_BYTE, 1'b1);
			frame_sum = 8'h00;
		end
		owed_bytes[owed_bytes.size() - 1].run_end = 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Driver: requests and receiver stall change on the falling edge
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		// a request that is still stalled stays put, payload unchanged
		if (arst_n && !(item_valid && !req_taken)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_req = pending_reqs.pop_front();
				item_valid <= 1'b1;
				data_byte  <= next_req.data;
				first_byte <= next_req.is_first;
				last_byte  <= next_req.is_last;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		byte_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// Monitor: everything is sampled on the rising edge
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		line_byte_t want;
		// register writes only happen while idle, so this ordering is safe
		if (escape_we)
			ctrl_escaping = escape_wdata;
		req_taken = item_valid && !item_stall;
		if (req_taken) begin
			encode_request(data_byte, first_byte, last_byte);
			reqs_encoded++;
		end
		if (byte_valid && !byte_stall) begin
			bytes_checked++;
			if (frame_end === 1'b1)
				frames_closed++;
			if (owed_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", out_byte));
			end else begin
				want = owed_bytes.pop_front();
				if (out_byte !== want.value)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						out_byte, want.value));
				if (run_end !== want.run_end)
					report_mismatch($sformatf("run_end %b, want %b (byte %02h)",
						run_end, want.run_end, want.value));
				if (frame_end !== want.frame_end)
					report_mismatch($sformatf("frame_end %b, want %b (byte %02h)",
						frame_end, want.frame_end, want.value));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic queue_request(input logic [7:0] d, input logic f, input logic l);
		payload_req_t r;
		r.data     = d;
		r.is_first = f;
		r.is_last  = l;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	// biased toward the bytes that hit the stuffing rules
	function automatic logic [7:0] pick_payload();
		case ($urandom_range(11))
			0: return bsfe_pkg::FLAG_BYTE;
			1: return bsfe_pkg::ESC_BYTE;
			2: return 8'($urandom_range(8'h1F));       // control range
			3: return $urandom_range(1) ? 8'h1F : 8'h20; // control boundary
			4: return $urandom_range(1) ? 8'h00 : 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly well-formed frames with random content; some broken or stray requests.
	task automatic queue_frame();
		int         len;
		logic [7:0] sum;
		logic [7:0] b;
		logic       drop_first;
		logic       drop_last;
		// stray request with random markers
		if ($urandom_range(11) == 0) begin
			queue_request(8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
			return;
		end
		len        = ($urandom_range(15) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
		drop_first = ($urandom_range(9) == 0);
		drop_last  = ($urandom_range(9) == 0);
		sum        = 8'h00;
		for (int i = 0; i < len; i++) begin
			b = pick_payload();
			// now and then steer the checksum onto the flag or the escape value
			if (i == len - 1 && $urandom_range(5) == 0)
				b = ($urandom_range(1) ? 8'h83 : 8'h82) - sum;
			sum = sum + b;
			queue_request(b, (i == 0) && !drop_first, (i == len - 1) && !drop_last);
		end
	endtask

	// all owed bytes out, then a short pause for the pipeline to settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (reqs_encoded != reqs_queued || owed_bytes.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_escape_mode(input logic mode);
		@(negedge clk);
		escape_we    <= 1'b1;
		escape_wdata <= mode;
		@(negedge clk);
		escape_we    <= 1'b0;
	endtask

	task automatic run_phase(input logic mode, input int send_pct, input int recv_pct,
			input int n_reqs);
		int target;
		wait_drained();
		write_escape_mode(mode);
		sender_idle_pct = send_pct;
		recv_stall_pct  = recv_pct;
		target = reqs_queued + n_reqs;
		while (reqs_queued < target)
			queue_frame();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, control escaping at its reset value
		sender_idle_pct = 23;
		recv_stall_pct  = 75;
		queue_request(8'h41, 1'b0, 1'b0);  // data with no frame open after reset
		queue_request(bsfe_pkg::FLAG_BYTE, 1'b0, 1'b1); // that continuation closes
		queue_request(bsfe_pkg::FLAG_BYTE, 1'b1, 1'b1); // one-byte frames of flag, escape
		queue_request(bsfe_pkg::ESC_BYTE, 1'b1, 1'b1);
		queue_request(8'h00, 1'b1, 1'b0);  // control range edges, then plain bytes
		queue_request(8'h1F, 1'b0, 1'b0);
		queue_request(8'h20, 1'b0, 1'b0);
		queue_request(8'hFF, 1'b0, 1'b0);
		queue_request(8'h80, 1'b0, 1'b1);
		queue_request(8'h02, 1'b1, 1'b0);  // checksum lands on the flag value
		queue_request(8'h80, 1'b0, 1'b1);
		queue_request(8'h03, 1'b1, 1'b0);  // checksum lands on the escape value
		queue_request(8'h80, 1'b0, 1'b1);
		queue_request(8'h55, 1'b1, 1'b0);  // frame cut short by a new first byte
		queue_request(8'h10, 1'b0, 1'b0);
		queue_request(8'hAA, 1'b1, 1'b0);
		queue_request(bsfe_pkg::ESC_BYTE, 1'b0, 1'b1);
		queue_request(8'h11, 1'b0, 1'b0);  // data after a frame end, no first
		queue_request(8'hFF, 1'b1, 1'b1);
		queue_request(8'h00, 1'b1, 1'b1);  // zero checksum

		// random part: escape mode alternates, idling pattern per phase
		run_phase(1'b0, 23, 75, 80);
		run_phase(1'b1, 75, 23, 80);
		run_phase(1'b0, 0, 0, 80);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Encoded %0d requests into %0d bytes, %0d frames closed,",
			reqs_encoded, bytes_checked, frames_closed);
		$display("%0d stuffed payload bytes, control escaping on and off, three idle patterns.",
			escapes_seen);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", error_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog, well beyond the slowest correct run
	initial begin
		#3000000;
		$display("Timeout with %0d of %0d requests taken, %0d bytes owed",
			reqs_encoded, reqs_queued, owed_bytes.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
